FILE: rtl/mhpq_pkg.sv
// Shared types, constants and helpers for the max-heap priority queue.
package mhpq_pkg;

	localparam int CAPACITY = 127;
	localparam int DATA_W   = 32;
	localparam int POS_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CHILD_W  = POS_W + 1;
	localparam int COUNT_W  = 7;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CHILD_W-1:0]       child_t;
	typedef logic [COUNT_W-1:0]       count_out_t;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_LOAD,
		ST_DN_CHK,
		ST_DN_CMP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		mode_t mode;
		data_t value;
	} req_t;

	typedef struct packed {
		status_t    status;
		data_t      top_value;
		logic       top_valid;
		count_out_t count;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic    ld_insert;
		logic    ld_remove;
		logic    rd_parent;
		logic    rd_child;
		logic    ld_elem;
		logic    up_move;
		logic    dn_move;
		logic    wr_elem;
		logic    out_load;
		status_t out_status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_root;
		logic up_swap;
		logic child_none;
		logic dn_swap;
		logic out_free;
	} dp_sts_t;

	// 1-based heap position to 0-based store index
	function automatic idx_t pos_to_idx(input pos_t p);
		pos_t d;
		d = p - pos_t'(1);
		return idx_t'(d);
	endfunction

	function automatic idx_t child_to_idx(input child_t c);
		child_t d;
		d = c - child_t'(1);
		return idx_t'(d);
	endfunction

endpackage

FILE: rtl/mhpq_ctrl.sv
// Sequencer for insert / sift-up and remove / sift-down.
module mhpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  mhpq_pkg::mode_t   req_mode,
	output logic              req_stall,
	input  mhpq_pkg::dp_sts_t sts,
	output mhpq_pkg::dp_cmd_t cmd
);

	mhpq_pkg::state_t  state_q;
	mhpq_pkg::state_t  state_nx;
	mhpq_pkg::status_t status_q;
	logic              accept;

	assign req_stall = (state_q != mhpq_pkg::ST_IDLE);
	assign accept    = req_valid && (state_q == mhpq_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// status of the transaction in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_mode == mhpq_pkg::MODE_INSERT && sts.full) begin
				status_q <= mhpq_pkg::STATUS_FULL;
			end else if (req_mode == mhpq_pkg::MODE_REMOVE && sts.empty) begin
				status_q <= mhpq_pkg::STATUS_EMPTY;
			end else begin
				status_q <= mhpq_pkg::STATUS_OK;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			mhpq_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_mode == mhpq_pkg::MODE_INSERT) begin
						state_nx = sts.full ? mhpq_pkg::ST_FINISH : mhpq_pkg::ST_UP_CHK;
					end else begin
						state_nx = sts.empty ? mhpq_pkg::ST_FINISH : mhpq_pkg::ST_DN_LOAD;
					end
				end
			end
			mhpq_pkg::ST_UP_CHK:  state_nx = sts.pos_root ? mhpq_pkg::ST_FINISH
			                                              : mhpq_pkg::ST_UP_CMP;
			mhpq_pkg::ST_UP_CMP:  state_nx = sts.up_swap ? mhpq_pkg::ST_UP_CHK
			                                             : mhpq_pkg::ST_FINISH;
			mhpq_pkg::ST_DN_LOAD: state_nx = mhpq_pkg::ST_DN_CHK;
			mhpq_pkg::ST_DN_CHK:  state_nx = sts.child_none ? mhpq_pkg::ST_FINISH
			                                                : mhpq_pkg::ST_DN_CMP;
			mhpq_pkg::ST_DN_CMP:  state_nx = sts.dn_swap ? mhpq_pkg::ST_DN_CHK
			                                             : mhpq_pkg::ST_FINISH;
			mhpq_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_nx = mhpq_pkg::ST_IDLE;
				end
			end
			default: state_nx = mhpq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.out_status = status_q;
		case (state_q)
			mhpq_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.ld_insert = (req_mode == mhpq_pkg::MODE_INSERT) && !sts.full;
					cmd.ld_remove = (req_mode == mhpq_pkg::MODE_REMOVE) && !sts.empty;
				end
			end
			mhpq_pkg::ST_UP_CHK: begin
				cmd.wr_elem   = sts.pos_root;
				cmd.rd_parent = !sts.pos_root;
			end
			mhpq_pkg::ST_UP_CMP: begin
				cmd.up_move = sts.up_swap;
				cmd.wr_elem = !sts.up_swap;
			end
			mhpq_pkg::ST_DN_LOAD: cmd.ld_elem = 1'b1;
			mhpq_pkg::ST_DN_CHK: begin
				cmd.wr_elem  = sts.child_none;
				cmd.rd_child = !sts.child_none;
			end
			mhpq_pkg::ST_DN_CMP: begin
				cmd.dn_move = sts.dn_swap;
				cmd.wr_elem = !sts.dn_swap;
			end
			mhpq_pkg::ST_FINISH: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_full_goes_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_mode == mhpq_pkg::MODE_INSERT && sts.full)
		|=> (state_q == mhpq_pkg::ST_FINISH && status_q == mhpq_pkg::STATUS_FULL))
		else $error("full insert did not finish directly");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.up_move, cmd.dn_move, cmd.wr_elem}))
		else $error("more than one store write");
	a_load_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == mhpq_pkg::ST_IDLE)
		else $error("result loaded but controller not idle");
`endif

endmodule

FILE: rtl/mhpq_dp.sv
// Heap store, count, sift registers and result register.
module mhpq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mhpq_pkg::data_t   req_value,
	input  mhpq_pkg::dp_cmd_t cmd,
	output mhpq_pkg::dp_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mhpq_pkg::rsp_t    rsp
);

	mhpq_pkg::data_t  mem [mhpq_pkg::CAPACITY];
	mhpq_pkg::data_t  rd_a_q;
	mhpq_pkg::data_t  rd_b_q;
	mhpq_pkg::data_t  elem_q;
	mhpq_pkg::data_t  top_q;
	mhpq_pkg::pos_t   count_q;
	mhpq_pkg::pos_t   pos_q;
	logic             out_valid_q;
	mhpq_pkg::rsp_t   out_q;

	mhpq_pkg::pos_t   parent;
	mhpq_pkg::child_t left;
	mhpq_pkg::child_t right;
	mhpq_pkg::child_t count_c;
	logic             right_ok;
	logic             pick_right;
	mhpq_pkg::data_t  big_val;
	mhpq_pkg::child_t big_pos;
	logic             rd_a_en;
	mhpq_pkg::idx_t   rd_a_idx;
	logic             wr_en;
	mhpq_pkg::pos_t   wr_pos;
	mhpq_pkg::data_t  wr_data;

	assign parent   = pos_q >> 1;
	assign left     = {pos_q, 1'b0};
	assign right    = {pos_q, 1'b1};
	assign count_c  = mhpq_pkg::child_t'(count_q);
	assign right_ok = (right <= count_c);

	assign pick_right = right_ok && (rd_b_q > rd_a_q);
	assign big_val    = pick_right ? rd_b_q : rd_a_q;
	assign big_pos    = pick_right ? right : left;

	assign sts.full       = (count_q == mhpq_pkg::pos_t'(mhpq_pkg::CAPACITY));
	assign sts.empty      = (count_q == '0);
	assign sts.pos_root   = (pos_q == mhpq_pkg::pos_t'(1));
	assign sts.up_swap    = (elem_q > rd_a_q);
	assign sts.child_none = (left > count_c);
	assign sts.dn_swap    = (big_val > elem_q);
	assign sts.out_free   = !out_valid_q || !rsp_stall;

	// read port A: last element, parent or left child
	assign rd_a_en = cmd.ld_remove || cmd.rd_parent || cmd.rd_child;
	always_comb begin
		if (cmd.ld_remove) begin
			rd_a_idx = mhpq_pkg::pos_to_idx(count_q);
		end else if (cmd.rd_parent) begin
			rd_a_idx = mhpq_pkg::pos_to_idx(parent);
		end else begin
			rd_a_idx = mhpq_pkg::child_to_idx(left);
		end
	end

	// single write port
	assign wr_en = cmd.up_move || cmd.dn_move || cmd.wr_elem;
	assign wr_pos = pos_q;
	always_comb begin
		if (cmd.up_move) begin
			wr_data = rd_a_q;
		end else if (cmd.dn_move) begin
			wr_data = big_val;
		end else begin
			wr_data = elem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			rd_a_q <= mem[rd_a_idx];
		end
		if (cmd.rd_child && right_ok) begin
			rd_b_q <= mem[mhpq_pkg::child_to_idx(right)];
		end
		if (wr_en) begin
			mem[mhpq_pkg::pos_to_idx(wr_pos)] <= wr_data;
		end
	end

	// sift registers and root copy
	always_ff @(posedge clk) begin
		if (cmd.ld_insert) begin
			elem_q <= req_value;
			pos_q  <= count_q + mhpq_pkg::pos_t'(1);
		end else if (cmd.ld_remove) begin
			pos_q <= mhpq_pkg::pos_t'(1);
		end else if (cmd.up_move) begin
			pos_q <= parent;
		end else if (cmd.dn_move) begin
			pos_q <= mhpq_pkg::pos_t'(big_pos);
		end
		if (cmd.ld_elem) begin
			elem_q <= rd_a_q;
		end
		if (wr_en && wr_pos == mhpq_pkg::pos_t'(1)) begin
			top_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ld_insert) begin
			count_q <= count_q + mhpq_pkg::pos_t'(1);
		end else if (cmd.ld_remove) begin
			count_q <= count_q - mhpq_pkg::pos_t'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status    <= cmd.out_status;
			out_q.top_value <= (count_q != '0) ? top_q : '0;
			out_q.top_valid <= (count_q != '0);
			out_q.count     <= mhpq_pkg::count_out_t'(count_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mhpq_pkg::pos_t'(mhpq_pkg::CAPACITY))
		else $error("element count above capacity");
	a_wr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_pos != '0 && wr_pos <= mhpq_pkg::pos_t'(mhpq_pkg::CAPACITY)))
		else $error("store write outside heap");
	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (out_q.top_valid == (count_q != '0)))
		else $error("top_valid disagrees with count");
`endif

endmodule

FILE: rtl/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue.
//
//   channel  | dir | payload          | handshake
//   ---------+-----+------------------+---------------------------
//   req      | in  | mode, value      | req_valid / req_stall
//   rsp      | out | status, top_*,   | rsp_valid / rsp_stall
//            |     | count            |
//
// One transaction at a time. Insert sifts the new element up and remove
// loads the last element and sifts it down, L levels, L being the levels the
// element moves (at most 6 at 127 entries); each level is a store read, a
// compare and one write-back through the single write port.
// Full insert and empty remove go straight to the finish state.
// Reset clears the count and the control; the store holds no valid bits and
// is never read beyond the count.
// A waiting result sits in the output register, so a stalled rsp holds the
// next request only once that request's own result is ready.
module max_heap_priority_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mhpq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mhpq_pkg::rsp_t rsp
);

	// command and status between sequencer and datapath
	mhpq_pkg::dp_cmd_t cmd;
	mhpq_pkg::dp_sts_t sts;

	// sequencer: accepts a transaction only when idle, then walks the sift
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: heap store, count, moving element and the result register
	mhpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_value (req.value),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
